>>> design/rsfr_pkg.sv
// Shared types and constants for the RTU silence frame receiver.
`timescale 1ns / 1ps
package rsfr_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

    localparam logic [7:0] SILENCE_RESET = 8'd4;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_RECEIVING = 2'd1,
        PH_RECEIVED  = 2'd2
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } rsfr_in_t;

    typedef struct packed {
        phase_t     phase;
        logic [8:0] frame_length;
        logic       frame_done;
        logic       overflowed;
        logic [7:0] read_data;
    } rsfr_out_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } rsfr_mem_req_t;

    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] count;
        logic             done;
        logic             ovf;
        logic             rd_en;
    } rsfr_stat_t;

endpackage

>>> design/rtu_silence_frame_receiver.sv
// Top level: RTU silence-delimited frame receiver with buffer and result pipeline.
//
// Usage:
//   s_valid/s_ready/s_data carry one item per beat: a received byte, a timer
//   tick, a frame release or a read of one buffer entry. Every item yields
//   exactly one result beat on m_valid/m_ready/m_data: phase, frame length,
//   frame-done pulse, overflow flag and, for reads, the buffer byte.
//   cfg_valid/cfg_ready/cfg_wdata write the silence count; cfg_ready is
//   always high. Write it only while no result is outstanding.
//   State update and buffer access happen at the accepting edge; the result
//   then waits in the stage-1 register until the output advances and loads
//   the output register. Throughput: one item per cycle while m_ready is high,
//   set by the single read-modify-write of the state registers and one buffer
//   port access. Reset: phase idle, timer, count and overflow cleared, silence
//   count 4. Buffer contents are not cleared. When m_ready is low, the two-entry
//   pipeline fills and s_ready drops; nothing is lost.
`timescale 1ns / 1ps
module rtu_silence_frame_receiver
    import rsfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  rsfr_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rsfr_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_wdata
);

    rsfr_mem_req_t mem_req;
    rsfr_stat_t    stat;
    logic [7:0]    ram_rdata;

    logic       accept;
    logic       adv;
    logic       s1_valid_reg, s1_valid_next;
    rsfr_stat_t s1_stat_reg;
    logic       m_valid_reg, m_valid_next;
    rsfr_out_t  out_reg;

    assign cfg_ready = 1'b1;
    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || adv;
    assign accept    = s_valid && s_ready;

    rsfr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (s_data),
        .mem_req   (mem_req),
        .stat      (stat)
    );

    rsfr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (ram_rdata)
    );

    assign s1_valid_next = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = adv ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_stat_reg <= stat;
        end
        if (adv && s1_valid_reg) begin
            out_reg.phase        <= s1_stat_reg.phase;
            out_reg.frame_length <= 9'(s1_stat_reg.count);
            out_reg.frame_done   <= s1_stat_reg.done;
            out_reg.overflowed   <= s1_stat_reg.ovf;
            out_reg.read_data    <= s1_stat_reg.rd_en ? ram_rdata : 8'd0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_done_received: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> m_data.phase == PH_RECEIVED)
        else $error("frame done outside received phase");

    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && m_valid_reg && !m_ready |-> !accept)
        else $error("item accepted with pipeline full");

    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_data != 8'd0 |-> m_data.frame_done == 1'b0)
        else $error("read data on a tick result");

endmodule

>>> design/rsfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/rsfr_ctrl.sv
// Receiver state update: phase, silence timer, byte count, overflow, buffer access.
`timescale 1ns / 1ps
module rsfr_ctrl
    import rsfr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata,
    input  logic          accept,
    input  rsfr_in_t      item,
    output rsfr_mem_req_t mem_req,
    output rsfr_stat_t    stat
);

    phase_t           phase_reg, phase_next;
    logic [7:0]       timer_reg, timer_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       silence_reg;

    logic [7:0] limit;
    logic [7:0] timer_inc;
    logic       timer_ge;
    logic       buf_room;
    logic       in_range;
    logic       done;

    assign limit     = (silence_reg == 8'd0) ? 8'd1 : silence_reg;
    assign timer_ge  = timer_reg >= limit;
    assign timer_inc = timer_ge ? timer_reg : timer_reg + 8'd1;
    assign buf_room  = 32'(count_reg) < 32'(BUF_DEPTH);
    assign in_range  = 32'(item.read_index) < 32'(BUF_DEPTH);

    always_comb begin
        phase_next    = phase_reg;
        timer_next    = timer_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        done          = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = ADDR_W'(count_reg);
        mem_req.wdata = item.rx_byte;
        mem_req.re    = 1'b0;
        mem_req.raddr = ADDR_W'(item.read_index);
        if (accept) begin
            case (item.kind)
                KIND_BYTE: begin
                    if (phase_reg == PH_IDLE) begin
                        if (timer_ge) begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = '0;
                            count_next    = CNT_W'(1);
                            ovf_next      = 1'b0;
                            timer_next    = 8'd0;
                            phase_next    = PH_RECEIVING;
                        end
                    end else if (phase_reg == PH_RECEIVING) begin
                        if (buf_room) begin
                            mem_req.we = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                        timer_next = 8'd0;
                    end
                end
                KIND_TICK: begin
                    if (phase_reg == PH_RECEIVING) begin
                        timer_next = timer_inc;
                        if (timer_inc >= limit) begin
                            phase_next = PH_RECEIVED;
                            done       = 1'b1;
                        end
                    end else if (phase_reg == PH_IDLE) begin
                        timer_next = timer_inc;
                    end
                end
                KIND_RELEASE: begin
                    if (phase_reg == PH_RECEIVED) begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
                KIND_READ: begin
                    mem_req.re = in_range;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            timer_reg   <= 8'd0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            silence_reg <= SILENCE_RESET;
        end else begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_we) begin
                silence_reg <= cfg_wdata;
            end
        end
    end

    assign stat.phase = phase_next;
    assign stat.count = count_next;
    assign stat.done  = done;
    assign stat.ovf   = ovf_next;
    assign stat.rd_en = accept && (item.kind == KIND_READ);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(BUF_DEPTH))
        else $error("byte count past buffer depth");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> 32'(count_reg) == 32'(BUF_DEPTH))
        else $error("overflow without full buffer");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> (count_reg == '0 && !ovf_reg))
        else $error("idle with frame contents");

    a_write_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.we |=> count_reg != '0 && phase_reg == PH_RECEIVING)
        else $error("buffer write outside a frame");

endmodule

>>> sim/testbench.sv
// Testbench for rtu_silence_frame_receiver: directed and random traffic against a model.
`timescale 1ns / 1ps
module testbench;
    import rsfr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    rsfr_in_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b1;
    rsfr_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [7:0] cfg_wdata = 8'd0;

    // receiver model state
    logic [7:0] mdl_silence = SILENCE_RESET;
    phase_t     mdl_phase   = PH_IDLE;
    logic [7:0] mdl_timer   = 8'd0;
    int         mdl_count   = 0;
    logic       mdl_ovf     = 1'b0;
    logic [7:0] mdl_store [0:BUF_DEPTH-1];
    int         mdl_filled  = 0;

    rsfr_out_t expected_status_q [$];

    bit src_idling  = 1'b1;
    bit sink_idling = 1'b1;
    int long_hold   = 0;
    int n_sent      = 0;
    int n_beats     = 0;
    int n_errors    = 0;
    int n_cycles    = 0;

    rtu_silence_frame_receiver u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int silence_limit();
        return (mdl_silence == 8'd0) ? 1 : int'(mdl_silence);
    endfunction

    function automatic rsfr_out_t advance_receiver(rsfr_in_t it);
        rsfr_out_t  r;
        logic [7:0] lim;
        r   = '0;
        lim = 8'(silence_limit());
        case (it.kind)
            KIND_BYTE: begin
                if (mdl_phase == PH_IDLE) begin
                    if (mdl_timer >= lim) begin
                        mdl_store[0] = it.rx_byte;
                        mdl_count    = 1;
                        mdl_ovf      = 1'b0;
                        mdl_timer    = 8'd0;
                        mdl_phase    = PH_RECEIVING;
                    end
                end else if (mdl_phase == PH_RECEIVING) begin
                    if (mdl_count < BUF_DEPTH) begin
                        mdl_store[mdl_count] = it.rx_byte;
                        mdl_count++;
                    end else begin
                        mdl_ovf = 1'b1;
                    end
                    mdl_timer = 8'd0;
                end
                if (mdl_count > mdl_filled) mdl_filled = mdl_count;
            end
            KIND_TICK: begin
                if (mdl_phase == PH_RECEIVING) begin
                    if (mdl_timer < lim) mdl_timer++;
                    if (mdl_timer >= lim) begin
                        mdl_phase    = PH_RECEIVED;
                        r.frame_done = 1'b1;
                    end
                end else if (mdl_phase == PH_IDLE) begin
                    if (mdl_timer < lim) mdl_timer++;
                end
            end
            KIND_RELEASE: begin
                if (mdl_phase == PH_RECEIVED) begin
                    mdl_phase = PH_IDLE;
                    mdl_count = 0;
                    mdl_ovf   = 1'b0;
                end
            end
            default: begin
                if (int'(it.read_index) < BUF_DEPTH) r.read_data = mdl_store[it.read_index];
            end
        endcase
        r.phase        = mdl_phase;
        r.frame_length = 9'(mdl_count);
        r.overflowed   = mdl_ovf;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (n_errors < 50) $display("mismatch at result beat %0d: %s", n_beats, what);
        n_errors++;
    endtask

    // v is the data byte for a byte item and the buffer index for a read
    task automatic send_item(kind_t k, logic [7:0] v);
        rsfr_in_t it;
        it.kind       = k;
        it.rx_byte    = (k == KIND_BYTE) ? v : 8'($urandom);
        it.read_index = (k == KIND_READ) ? v : 8'($urandom);
        if (src_idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        expected_status_q.push_back(advance_receiver(it));
        n_sent++;
    endtask

    task automatic ticks(int n);
        repeat (n) send_item(KIND_TICK, 8'($urandom));
    endtask

    task automatic send_read_any();
        if (mdl_filled > 0) send_item(KIND_READ, 8'($urandom_range(0, mdl_filled - 1)));
    endtask

    task automatic send_noise();
        kind_t k;
        k = kind_t'($urandom_range(0, 3));
        if (k == KIND_READ && mdl_filled == 0) k = KIND_TICK;
        if (k == KIND_READ) send_read_any();
        else send_item(k, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_silence(logic [7:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        mdl_silence  = v;
    endtask

    task automatic random_frame();
        int lim;
        int len;
        lim = silence_limit();
        // lead-in silence, now and then too short so the first bytes are dropped
        ticks(($urandom_range(0, 4) == 0) ? $urandom_range(0, lim) : lim + $urandom_range(0, 2));
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
            send_item(KIND_BYTE, 8'($urandom));
            if (lim > 1 && $urandom_range(0, 5) == 0) ticks($urandom_range(1, lim - 1));
        end
        ticks(($urandom_range(0, 4) == 0) ? $urandom_range(0, lim - 1)
                                          : lim + $urandom_range(0, 2));
        repeat ($urandom_range(0, 3)) send_read_any();
        if ($urandom_range(0, 7) != 0) send_item(KIND_RELEASE, 8'($urandom));
        repeat ($urandom_range(0, 2)) send_noise();
    endtask

    task automatic test_reset_and_basic_frames();
        send_item(KIND_BYTE, 8'hFF);        // timer 0 after reset: dropped
        ticks(3);
        send_item(KIND_BYTE, 8'h00);        // short silence: dropped, timer kept
        ticks(2);                           // reaches count, then saturates
        send_item(KIND_BYTE, 8'hA5);        // frame start
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        ticks(3);
        send_item(KIND_BYTE, 8'h5A);        // timer restarts
        ticks(4);                           // frame done on the last one
        send_item(KIND_TICK, 8'h00);        // received: no change
        send_item(KIND_BYTE, 8'h11);        // received: dropped
        send_item(KIND_READ, 8'd0);
        send_item(KIND_READ, 8'd3);
        send_item(KIND_RELEASE, 8'h00);
        send_item(KIND_RELEASE, 8'h00);     // idle: ignored
        send_item(KIND_BYTE, 8'h3C);        // silence kept across release
        ticks(4);
        send_item(KIND_RELEASE, 8'h00);
    endtask

    task automatic test_silence_extremes();
        write_silence(8'd0);                // behaves as 1
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_RELEASE, 8'h00);
        write_silence(8'd255);
        ticks(254);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_BYTE, 8'hFE);
        ticks(255);
        send_item(KIND_RELEASE, 8'h00);
        write_silence(8'd8);                // timer already past the new count
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_BYTE, 8'h7E);
        ticks(5);
        write_silence(8'd2);                // count lowered below the timer mid-frame
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_RELEASE, 8'h00);
        write_silence(8'd3);
        send_item(KIND_BYTE, 8'hC3);
        ticks(3);
        send_item(KIND_RELEASE, 8'h00);
    endtask

    task automatic test_buffer_overflow();
        write_silence(8'd1);
        ticks(1);
        repeat (BUF_DEPTH + 3) send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_READ, 8'd0);
        send_item(KIND_READ, 8'd255);
        send_item(KIND_READ, 8'hAA);
        send_item(KIND_READ, 8'h55);
        ticks(1);
        send_item(KIND_BYTE, 8'h42);        // received: dropped even when full
        send_item(KIND_READ, 8'd255);
        send_item(KIND_RELEASE, 8'h00);     // clears count and overflow
    endtask

    task automatic test_backpressure();
        src_idling  = 1'b0;
        sink_idling = 1'b0;
        long_hold   = 120;
        repeat (40) send_noise();
        wait_drained();
        src_idling  = 1'b1;
        sink_idling = 1'b1;
    endtask

    task automatic test_random_traffic();
        logic [7:0] setting;
        int         goal;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: setting = 8'd1;
                1: setting = 8'd32;
                2: setting = 8'd0;
                3: setting = 8'd2;
                7: setting = SILENCE_RESET;
                default: setting = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(11, 32))
                                                               : 8'($urandom_range(1, 10));
            endcase
            src_idling  = (p != 3) && (p != 7);
            sink_idling = (p != 5) && (p != 7);
            write_silence(setting);
            goal = n_sent + 115;
            while (n_sent < goal) random_frame();
        end
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (long_hold > 0) begin
                m_ready <= 1'b0;
                repeat (long_hold) @(posedge aclk);
                long_hold = 0;
                m_ready <= 1'b1;
            end else if (sink_idling && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        rsfr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_status_q.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want = expected_status_q.pop_front();
                if (m_data.phase !== want.phase)
                    report_mismatch($sformatf("phase %0d, want %0d", m_data.phase, want.phase));
                if (m_data.frame_length !== want.frame_length)
                    report_mismatch($sformatf("frame_length %0d, want %0d",
                                              m_data.frame_length, want.frame_length));
                if (m_data.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done %b, want %b",
                                              m_data.frame_done, want.frame_done));
                if (m_data.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed %b, want %b",
                                              m_data.overflowed, want.overflowed));
                if (m_data.read_data !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h",
                                              m_data.read_data, want.read_data));
            end
            n_beats++;
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_and_basic_frames();
        test_silence_extremes();
        test_buffer_overflow();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (n_errors == 0 && expected_status_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
